// ----- src/dtpf_pkg.sv -----
// Shared types, constants and helpers for the dynamic-threshold packet FIFO.
// No dependencies; imported by dtpf_store, dynamic_threshold_packet_fifo, dtpf_checker and the testbench top.
package dtpf_pkg;

    // Default number of descriptor slots
    localparam int unsigned FIFO_DEPTH_DEF = 256;

    // Field widths
    localparam int unsigned SIZE_W   = 16;
    localparam int unsigned PORT_W   = 16;
    localparam int unsigned FLOW_W   = 15;
    localparam int unsigned BYTES_W  = 25;
    localparam int unsigned ALPHA_W  = 6;
    localparam int unsigned BUFFER_W = 24;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CFG_ADDR_W = 2;

    // Flow classification
    localparam logic [PORT_W-1:0] PORT_LIMIT   = 16'd30000;
    localparam logic [FLOW_W-1:0] DEFAULT_FLOW = 15'd1001;

    // Register reset values and byte counter ceiling
    localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 6'd14;
    localparam logic [BUFFER_W-1:0] BUFFER_RST = 24'd1048576;
    localparam logic [BYTES_W-1:0]  BYTES_MAX  = 25'h1FF_FFFF;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_ALPHA  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BUFFER = 2'd1;

    // Commands
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ENQ         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DROP_THRESH = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROP_FULL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DEQ         = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd4;

    // One stored packet descriptor
    typedef struct packed {
        logic [FLOW_W-1:0] flow;
        logic [SIZE_W-1:0] size;
    } dtpf_entry_t;

    // Pick the flow id: source port, else destination port, else the default
    function automatic logic [FLOW_W-1:0] flow_of(input logic [PORT_W-1:0] sp,
                                                  input logic [PORT_W-1:0] dp);
        logic [FLOW_W-1:0] f;
        if (sp < PORT_LIMIT) begin
            f = sp[FLOW_W-1:0];
        end else if (dp < PORT_LIMIT) begin
            f = dp[FLOW_W-1:0];
        end else begin
            f = DEFAULT_FLOW;
        end
        return f;
    endfunction

endpackage

// ----- src/dtpf_store.sv -----
// Descriptor memory with a registered read port and write-to-read bypass.
// Depends on dtpf_pkg for the entry type.
module dtpf_store
    import dtpf_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [$clog2(FIFO_DEPTH)-1:0] wr_addr,
    input  dtpf_entry_t                   wr_entry,
    input  logic [$clog2(FIFO_DEPTH)-1:0] rd_addr,
    output dtpf_entry_t                   rd_entry
);

    dtpf_entry_t mem [FIFO_DEPTH];
    dtpf_entry_t mem_q_reg;
    dtpf_entry_t byp_entry_reg;
    logic        byp_hit_reg;

    // Write one descriptor per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
    end

    // Read registered; remember a same-address write for the bypass
    always_ff @(posedge aclk) begin
        mem_q_reg     <= mem[rd_addr];
        byp_entry_reg <= wr_entry;
        byp_hit_reg   <= wr_en && (wr_addr == rd_addr);
    end

    // Forward the word written at the read address
    assign rd_entry = byp_hit_reg ? byp_entry_reg : mem_q_reg;

endmodule

// ----- src/dynamic_threshold_packet_fifo.sv -----
// Dynamic-threshold packet FIFO: stream front end, admission and byte counting.
// Results are registered: an accepted input word passes the input register and then
// the result register. Throughput: one word per cycle unless the receiver holds off;
// the execute stage reads a prefetched head entry, so the descriptor memory read port
// keeps pace with back-to-back dequeues.
// Reset (aresetn low, synchronous): queue empty, alpha 14, buffer 1048576 bytes;
// descriptor memory is left uninitialized and needs no clearing pass.
// Depends on dtpf_pkg and dtpf_store.
module dynamic_threshold_packet_fifo
    import dtpf_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_wr_addr,
    input  logic [BUFFER_W-1:0]   cfg_wr_data,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,   // pkt_len[15:0], src_port[31:16], dst_port[47:32]
    input  logic                  s_tuser,   // cmd[0]
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [55:0]           m_tdata,   // out_size[15:0], out_flow[30:16], queued_total[55:31]
    output logic [STATUS_W-1:0]   m_tuser    // status[2:0]
);

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration registers
    logic [ALPHA_W-1:0]  alpha_reg;
    logic [BUFFER_W-1:0] buffer_reg;

    // Input register
    logic              in_valid_reg;
    logic              in_cmd_reg;
    logic [SIZE_W-1:0] in_size_reg;
    logic [PORT_W-1:0] in_sp_reg;
    logic [PORT_W-1:0] in_dp_reg;

    // Queue state
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [BYTES_W-1:0] queued_reg, queued_next;

    // Result register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [SIZE_W-1:0]   out_size_reg, out_size_next;
    logic [FLOW_W-1:0]   out_flow_reg, out_flow_next;

    // Execute stage signals
    logic                exec;
    logic                in_accept;
    logic                is_full;
    logic                is_empty;
    logic                admit;
    logic                enq_ok;
    logic                deq_ok;
    logic signed [25:0]  remaining;
    logic signed [32:0]  limit;
    logic [25:0]         sum;
    logic [PTR_W-1:0]    head_inc;
    logic [PTR_W-1:0]    tail_inc;
    dtpf_entry_t         wr_entry;
    dtpf_entry_t         head_entry;

    // Stream handshake: execute when the result slot is free or being drained
    assign exec      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || exec;
    assign in_accept = s_tvalid && s_tready;

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg  <= ALPHA_RST;
            buffer_reg <= BUFFER_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_addr)
                CFG_ALPHA:  alpha_reg  <= cfg_wr_data[ALPHA_W-1:0];
                CFG_BUFFER: buffer_reg <= cfg_wr_data;
                default:    ;
            endcase
        end
    end

    // Capture input word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_cmd_reg  <= s_tuser;
            in_size_reg <= s_tdata[15:0];
            in_sp_reg   <= s_tdata[31:16];
            in_dp_reg   <= s_tdata[47:32];
        end
    end

    // Admission test: queued <= alpha * (buffer - queued), signed
    assign remaining = $signed({2'b00, buffer_reg}) - $signed({1'b0, queued_reg});
    assign limit     = $signed({1'b0, alpha_reg}) * remaining;
    assign admit     = $signed({8'd0, queued_reg}) <= limit;

    assign is_full  = (count_reg == CNT_W'(FIFO_DEPTH));
    assign is_empty = (count_reg == '0);
    assign enq_ok   = exec && (in_cmd_reg == CMD_ENQ) && !is_full && admit;
    assign deq_ok   = exec && (in_cmd_reg == CMD_DEQ) && !is_empty;

    // Pointer wrap at the configured depth
    assign head_inc = (head_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    assign sum = {1'b0, queued_reg} + {10'd0, in_size_reg};

    // Execute one command
    always_comb begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        queued_next     = queued_reg;
        out_status_next = ST_EMPTY;
        out_size_next   = '0;
        out_flow_next   = '0;
        if (in_cmd_reg == CMD_ENQ) begin
            if (is_full) begin
                out_status_next = ST_DROP_FULL;
            end else if (admit) begin
                out_status_next = ST_ENQ;
                tail_next       = tail_inc;
                count_next      = count_reg + 1'b1;
                queued_next     = sum[25] ? BYTES_MAX : sum[BYTES_W-1:0];
            end else begin
                out_status_next = ST_DROP_THRESH;
            end
        end else if (!is_empty) begin
            out_status_next = ST_DEQ;
            out_size_next   = head_entry.size;
            out_flow_next   = head_entry.flow;
            head_next       = head_inc;
            count_next      = count_reg - 1'b1;
            queued_next     = (queued_reg >= {9'd0, head_entry.size})
                            ? queued_reg - {9'd0, head_entry.size} : '0;
        end
    end

    // Advance queue state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            queued_reg <= '0;
        end else if (exec) begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            queued_reg <= queued_next;
        end
    end

    // Hold result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (exec) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            out_status_reg <= out_status_next;
            out_size_reg   <= out_size_next;
            out_flow_reg   <= out_flow_next;
        end
    end

    // Descriptor store; read address tracks the head after this cycle's step
    assign wr_entry.size = in_size_reg;
    assign wr_entry.flow = flow_of(in_sp_reg, in_dp_reg);

    dtpf_store #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_store (
        .aclk     (aclk),
        .wr_en    (enq_ok),
        .wr_addr  (tail_reg),
        .wr_entry (wr_entry),
        .rd_addr  (deq_ok ? head_inc : head_reg),
        .rd_entry (head_entry)
    );

    // queued_reg only moves with exec, which also loads the result word
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {queued_reg, out_flow_reg, out_size_reg};

    // Occupancy never exceeds the store depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("entry count above depth");

    // An empty queue holds no bytes
    a_empty_no_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (queued_reg == '0))
        else $error("bytes queued with no entries");

    // Admitted enqueue adds exactly one entry
    a_enq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        enq_ok |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("enqueue count mismatch");

    // Dequeue on an empty queue reports empty
    a_deq_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec && (in_cmd_reg == CMD_DEQ) && is_empty) |=>
            (m_tvalid && (m_tuser == ST_EMPTY)))
        else $error("empty dequeue not reported");

endmodule

// ----- tb/sv/dtpf_checker.sv -----
// Result checker for the dynamic-threshold packet FIFO: tracks register writes,
// predicts one result word per accepted input word and compares in order.
// Depends on dtpf_pkg; instantiated beside the block by the testbench top.
module dtpf_checker
    import dtpf_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_wr_addr,
    input  logic [BUFFER_W-1:0]   cfg_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [47:0]           s_tdata,   // pkt_len[15:0], src_port[31:16], dst_port[47:32]
    input  logic                  s_tuser,   // cmd[0]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [55:0]           m_tdata,   // out_size[15:0], out_flow[30:16], queued_total[55:31]
    input  logic [STATUS_W-1:0]   m_tuser,   // status[2:0]
    output int unsigned           pending_words,
    output int unsigned           mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDX_W = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SIZE_W-1:0]   size;
        logic [FLOW_W-1:0]   flow;
        logic [BYTES_W-1:0]  total;
    } fifo_report_t;

    // Shadow copy of the descriptor queue and the byte counter
    logic [SIZE_W-1:0]   slot_size [FIFO_DEPTH];
    logic [FLOW_W-1:0]   slot_flow [FIFO_DEPTH];
    int unsigned         rd_idx;
    int unsigned         wr_idx;
    int unsigned         held;
    logic [BYTES_W-1:0]  byte_count;
    logic [ALPHA_W-1:0]  alpha_reg;
    logic [BUFFER_W-1:0] buffer_reg;

    fifo_report_t        due_reports [$];
    int unsigned         fail_total = 0;

    // Apply one enqueue or dequeue to the shadow queue and return its report
    function automatic fifo_report_t apply_word(input logic cmd,
                                                input logic [SIZE_W-1:0] size,
                                                input logic [PORT_W-1:0] sp,
                                                input logic [PORT_W-1:0] dp);
        fifo_report_t r;
        longint       room;
        logic [BYTES_W:0] sum;
        r = '0;
        if (cmd == CMD_ENQ) begin
            // remaining space may go negative once the buffer is shrunk
            room = longint'(buffer_reg) - longint'(byte_count);
            if (held >= FIFO_DEPTH) begin
                r.status = ST_DROP_FULL;
            end else if (longint'(byte_count) <= longint'(alpha_reg) * room) begin
                slot_size[IDX_W'(wr_idx)] = size;
                if (sp < PORT_LIMIT) begin
                    slot_flow[IDX_W'(wr_idx)] = sp[FLOW_W-1:0];
                end else if (dp < PORT_LIMIT) begin
                    slot_flow[IDX_W'(wr_idx)] = dp[FLOW_W-1:0];
                end else begin
                    slot_flow[IDX_W'(wr_idx)] = DEFAULT_FLOW;
                end
                wr_idx = (wr_idx + 1) % FIFO_DEPTH;
                held++;
                sum = {1'b0, byte_count} + {10'd0, size};
                byte_count = sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];
                r.status = ST_ENQ;
            end else begin
                r.status = ST_DROP_THRESH;
            end
        end else if (held == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.status = ST_DEQ;
            r.size   = slot_size[IDX_W'(rd_idx)];
            r.flow   = slot_flow[IDX_W'(rd_idx)];
            rd_idx   = (rd_idx + 1) % FIFO_DEPTH;
            held--;
            byte_count = (byte_count >= BYTES_W'(r.size))
                       ? byte_count - BYTES_W'(r.size) : '0;
        end
        r.total = byte_count;
        return r;
    endfunction

    // Flag one field that differs from the prediction
    function automatic void check_field(input string name, input longint unsigned want,
                                        input logic [BYTES_W-1:0] got);
        if (got !== want[BYTES_W-1:0]) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_total++;
        end
    endfunction

    // Watch register writes and both channels at every rising edge
    always @(posedge aclk) begin : watch
        fifo_report_t want;
        if (!aresetn) begin
            rd_idx     = 0;
            wr_idx     = 0;
            held       = 0;
            byte_count = '0;
            alpha_reg  = ALPHA_RST;
            buffer_reg = BUFFER_RST;
            due_reports.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_addr)
                    CFG_ALPHA:  alpha_reg  = cfg_wr_data[ALPHA_W-1:0];
                    CFG_BUFFER: buffer_reg = cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                due_reports.push_back(apply_word(s_tuser, s_tdata[15:0],
                                                 s_tdata[31:16], s_tdata[47:32]));
            end
            if (m_tvalid && m_tready) begin
                if (due_reports.size() == 0) begin
                    $error("result word with no expectation waiting: status %0d", m_tuser);
                    fail_total++;
                end else begin
                    want = due_reports.pop_front();
                    check_field("status", 64'(want.status), BYTES_W'(m_tuser));
                    check_field("out_size", 64'(want.size), BYTES_W'(m_tdata[15:0]));
                    check_field("out_flow", 64'(want.flow), BYTES_W'(m_tdata[30:16]));
                    check_field("queued_total", 64'(want.total), m_tdata[55:31]);
                end
            end
        end
        pending_words  <= due_reports.size();
        mismatch_count <= fail_total;
    end

endmodule

// ----- tb/sv/tb_dynamic_threshold_packet_fifo.sv -----
// Testbench top for the dynamic-threshold packet FIFO: clock, reset, stimulus,
// receiver back-pressure and the final verdict.
// Depends on dtpf_pkg, dynamic_threshold_packet_fifo and dtpf_checker.
module tb_dynamic_threshold_packet_fifo
    import dtpf_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD  = 300;
    localparam int N_PHASES   = 12;
    localparam int FILL_PHASE = 3;
    localparam int DRAIN_PHASE = 4;
    // indexes past the last register; writes there must be ignored
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_wr_addr;
    logic [BUFFER_W-1:0]   cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [47:0]           s_tdata;   // pkt_len[15:0], src_port[31:16], dst_port[47:32]
    logic                  s_tuser;   // cmd[0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [55:0]           m_tdata;   // out_size[15:0], out_flow[30:16], queued_total[55:31]
    logic [STATUS_W-1:0]   m_tuser;   // status[2:0]

    int unsigned pending_words;
    int unsigned mismatch_count;

    bit idle_en       = 1'b1;
    int hold_requests = 0;
    int holds_served  = 0;
    int sink_wait     = 0;

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    dynamic_threshold_packet_fifo dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_addr (cfg_wr_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    dtpf_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_addr    (cfg_wr_addr),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .pending_words  (pending_words),
        .mismatch_count (mismatch_count)
    );

    // Receiver: random stall bursts, plus a long hold when one is requested
    always @(posedge aclk) begin : result_sink
        if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
            m_tready  <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            sink_wait    <= LONG_HOLD - 1;
            m_tready     <= 1'b0;
        end else if (idle_en && $urandom_range(0, 99) < 8) begin
            sink_wait <= $urandom_range(0, 18);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Offer one word and hold it until accepted; may idle first
    task automatic send_word(input logic cmd, input logic [15:0] size,
                             input logic [15:0] sp, input logic [15:0] dp);
        if (idle_en && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {dp, sp, size};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic wait_drained;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [BUFFER_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_wr_addr <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Pick alpha and buffer size for a phase, extremes weighted in
    task automatic pick_config;
        logic [ALPHA_W-1:0]  a;
        logic [BUFFER_W-1:0] b;
        case ($urandom_range(0, 3))
            0:       a = '0;
            1:       a = '1;
            2:       a = ALPHA_RST;
            default: a = ALPHA_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       b = '0;
            1:       b = '1;
            2:       b = BUFFER_RST;
            3:       b = BUFFER_W'($urandom_range(0, 300000));
            default: b = BUFFER_W'($urandom);
        endcase
        write_reg(CFG_ALPHA, {18'($urandom), a});
        write_reg(CFG_BUFFER, b);
        if ($urandom_range(0, 2) == 0) begin
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, BUFFER_W'($urandom));
        end
    endtask

    function automatic logic [15:0] pick_size(input bit short_only);
        if (short_only) begin
            return 16'($urandom_range(0, 4095));
        end
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    // Cover each branch of the flow id choice and its boundaries
    function automatic void pick_ports(output logic [15:0] sp, output logic [15:0] dp);
        sp = 16'($urandom);
        dp = 16'($urandom);
        case ($urandom_range(0, 5))
            0: sp = 16'($urandom_range(0, 29999));
            1: begin
                sp = 16'($urandom_range(30000, 65535));
                dp = 16'($urandom_range(0, 29999));
            end
            2: begin
                sp = 16'($urandom_range(30000, 65535));
                dp = 16'($urandom_range(30000, 65535));
            end
            3: begin
                sp = $urandom_range(0, 1) ? PORT_LIMIT : PORT_LIMIT - 16'd1;
                dp = $urandom_range(0, 1) ? PORT_LIMIT : PORT_LIMIT - 16'd1;
            end
            default: ;
        endcase
    endfunction

    // Random enqueue/dequeue mix; optionally request a long receiver hold
    task automatic run_phase(input int words, input int enq_pct, input bit short_only,
                             input int hold_at);
        logic [15:0] sp;
        logic [15:0] dp;
        for (int k = 0; k < words; k++) begin
            if (k == hold_at) begin
                hold_requests <= hold_requests + 1;
            end
            pick_ports(sp, dp);
            if ($urandom_range(1, 100) <= enq_pct) begin
                send_word(CMD_ENQ, pick_size(short_only), sp, dp);
            end else begin
                send_word(CMD_DEQ, pick_size(1'b0), sp, dp);
            end
        end
    endtask

    initial begin : stimulus
        int enq_pct;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_addr <= CFG_ALPHA;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tuser     <= CMD_ENQ;
        s_tdata     <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset registers: empty dequeue, size and flow id extremes, then drain
        send_word(CMD_DEQ, '1, '1, '1);
        send_word(CMD_ENQ, '0, '0, '0);
        send_word(CMD_ENQ, '1, PORT_LIMIT - 16'd1, '1);
        send_word(CMD_ENQ, 16'd1, PORT_LIMIT, PORT_LIMIT - 16'd1);
        send_word(CMD_ENQ, 16'd1500, '1, PORT_LIMIT);
        send_word(CMD_ENQ, 16'd40, '1, '0);
        repeat (6) send_word(CMD_DEQ, '0, '0, '0);

        // Zero alpha and buffer: admit only while no bytes are queued
        wait_drained;
        write_reg(CFG_ALPHA, '0);
        write_reg(CFG_BUFFER, '0);
        send_word(CMD_ENQ, 16'd100, 16'd12345, '0);
        send_word(CMD_ENQ, 16'd5, 16'd7, '0);
        send_word(CMD_DEQ, '0, '0, '0);

        // Largest settings, then shrink the buffer under the queued bytes
        wait_drained;
        write_reg(CFG_ALPHA, '1);
        write_reg(CFG_BUFFER, '1);
        repeat (3) send_word(CMD_ENQ, '1, 16'd443, 16'd80);
        wait_drained;
        write_reg(CFG_BUFFER, 24'd1000);
        send_word(CMD_ENQ, 16'd10, 16'd443, 16'd80);
        repeat (3) send_word(CMD_DEQ, '0, '0, '0);
        send_word(CMD_ENQ, 16'd10, 16'd443, 16'd80);
        send_word(CMD_DEQ, '0, '0, '0);
        wait_drained;

        // Random phases, each under its own register setting
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph >= N_PHASES - 2) begin
                idle_en <= 1'b0;
            end
            if (ph == FILL_PHASE) begin
                // fill the store past its depth while the receiver holds off
                write_reg(CFG_ALPHA, '1);
                write_reg(CFG_BUFFER, '1);
                run_phase(350, 97, 1'b1, 40);
            end else begin
                pick_config;
                case ($urandom_range(0, 3))
                    0:       enq_pct = 30;
                    1:       enq_pct = 50;
                    2:       enq_pct = 60;
                    default: enq_pct = 75;
                endcase
                if (ph == DRAIN_PHASE) begin
                    enq_pct = 15;
                end
                run_phase(130, enq_pct, 1'b0, -1);
            end
            wait_drained;
        end

        // Catch any stray result words before the verdict
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && pending_words == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Hard stop well past the slowest legitimate run
    initial begin : watchdog
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
